// ===== src/sstp_pkg.sv =====
`timescale 1ns / 1ps

package sstp_pkg;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER    = 3'b001,
        PH_FORMATTED = 3'b010,
        PH_STRINGS   = 3'b100
    } t_phase;

    // table end status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TRUNC_HDR  = 3'd1,
        ST_SHORT_LEN  = 3'd2,
        ST_DATA_ENDS  = 3'd3,
        ST_TOO_LONG   = 3'd4
    } t_status;

    localparam logic       KIND_STRUCT   = 1'b0;
    localparam logic       KIND_TABLE_END = 1'b1;
    localparam logic [23:0] MAX_TABLE_RESET = 24'hFF_FFFF;
    localparam logic [23:0] OFFSET_OUT_MAX  = 24'hFF_FFFF;
    localparam logic [7:0]  HEADER_LEN      = 8'd4;

    // results of one input byte: an optional structure record followed by an
    // optional table end record
    typedef struct packed {
        logic        has_struct;
        logic        has_end;
        logic [7:0]  s_type;
        logic [15:0] s_handle;
        logic [7:0]  s_length;
        logic [7:0]  s_count;
        logic [23:0] s_offset;
        logic [23:0] e_offset;
        logic [15:0] e_total;
        t_status     e_status;
    } t_slot;

endpackage

// ===== src/smbios_structure_table_parser.sv =====
`timescale 1ns / 1ps

// channel      | direction | handshake               | payload
// -------------+-----------+-------------------------+--------------------------------------
// config       | in        | i_cfg_wr_en             | i_cfg_wr_data (max_table_bytes)
// table bytes  | in        | i_in_valid / o_in_stall | i_data_byte, i_last_byte
// records      | out       | o_out_valid / i_out_stall | o_record_kind .. o_last_result
//
// one byte per cycle while o_in_stall is low: the byte is parsed at its accepting
// edge and its records land in a two-entry result queue; a byte that raises two
// records sends them as two output transactions, so sustained rate is one byte
// per cycle while at most one record per byte comes out, and the queue depth sets
// how long input keeps going under output stall. reset is synchronous, active low,
// and clears parser state, the queue and sets max_table_bytes to all ones. o_in_stall
// is high only while both queue entries are occupied.

module smbios_structure_table_parser #(
    parameter int OFFSET_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_wr_en,
    input  logic [23:0]         i_cfg_wr_data,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_record_kind,
    output logic [7:0]          o_struct_type,
    output logic [15:0]         o_struct_handle,
    output logic [7:0]          o_formatted_length,
    output logic [7:0]          o_string_count,
    output logic [23:0]         o_struct_offset,
    output logic [15:0]         o_struct_total,
    output sstp_pkg::t_status   o_status,
    output logic                o_last_result
);

    import sstp_pkg::*;

    // width used to compare byte positions against 24-bit quantities
    localparam int WIDE = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    // clamp a byte position to the 24-bit offset field
    function automatic logic [23:0] sat_offset(input logic [OFFSET_BITS-1:0] p);
        logic [WIDE-1:0] ext;
        ext = WIDE'(p);
        if (ext > WIDE'(OFFSET_OUT_MAX))
            return OFFSET_OUT_MAX;
        else
            return ext[23:0];
    endfunction

    function automatic logic [OFFSET_BITS-1:0] pos_inc(input logic [OFFSET_BITS-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    // configuration
    logic [23:0]            r_max_bytes;

    // parser state
    t_phase                 r_phase,        n_phase;
    logic [1:0]             r_hdr_seen,     n_hdr_seen;
    logic [7:0]             r_type,         n_type;
    logic [7:0]             r_length,       n_length;
    logic [15:0]            r_handle,       n_handle;
    logic [7:0]             r_fmt_left,     n_fmt_left;
    logic [7:0]             r_strings,      n_strings;
    logic                   r_inside,       n_inside;
    logic [OFFSET_BITS-1:0] r_pos,          n_pos;
    logic [OFFSET_BITS-1:0] r_start,        n_start;
    logic [15:0]            r_done,         n_done;
    logic                   r_failed,       n_failed;

    // result queue, two entries of up to two records each
    t_slot                  r_slot [2];
    logic                   r_head, r_tail;
    logic [1:0]             r_count;
    logic                   r_half;     // structure record of head entry already sent

    logic                   in_accept;
    logic                   out_accept;
    logic                   push;
    logic                   pop;
    logic                   emit_struct;
    logic                   emit_end;
    t_status                err;
    logic [23:0]            end_offset;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [7:0]             fmt_dec;
    logic                   set_ends;
    t_slot                  new_slot;
    t_slot                  head_slot;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_count == 2'd2);

    assign pos_next = pos_inc(r_pos);
    assign fmt_dec  = r_fmt_left - 8'd1;

    // per-byte parse
    always_comb begin
        n_phase     = r_phase;
        n_hdr_seen  = r_hdr_seen;
        n_type      = r_type;
        n_length    = r_length;
        n_handle    = r_handle;
        n_fmt_left  = r_fmt_left;
        n_strings   = r_strings;
        n_inside    = r_inside;
        n_pos       = r_pos;
        n_start     = r_start;
        n_done      = r_done;
        n_failed    = r_failed;
        err         = ST_OK;
        emit_struct = 1'b0;
        emit_end    = 1'b0;
        set_ends    = 1'b0;
        end_offset  = '0;

        if (!r_failed) begin
            if (WIDE'(r_pos) >= WIDE'(r_max_bytes)) begin
                err = ST_TOO_LONG;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        case (r_hdr_seen)
                            2'd0: begin
                                n_type  = i_data_byte;
                                n_start = r_pos;
                            end
                            2'd1: n_length = i_data_byte;
                            2'd2: n_handle = {8'd0, i_data_byte};
                            default: n_handle = {i_data_byte, r_handle[7:0]};
                        endcase
                        if (r_hdr_seen != 2'd3) begin
                            n_hdr_seen = r_hdr_seen + 2'd1;
                            if (i_last_byte)
                                err = ST_TRUNC_HDR;
                        end else begin
                            n_hdr_seen = 2'd0;
                            if (r_length < HEADER_LEN) begin
                                err = ST_SHORT_LEN;
                            end else if (i_last_byte) begin
                                err = ST_DATA_ENDS;
                            end else begin
                                n_fmt_left = r_length - HEADER_LEN;
                                n_strings  = 8'd0;
                                n_inside   = 1'b0;
                                n_phase    = (r_length != HEADER_LEN) ? PH_FORMATTED
                                                                      : PH_STRINGS;
                            end
                        end
                    end
                    PH_FORMATTED: begin
                        if (i_last_byte) begin
                            err = ST_DATA_ENDS;
                        end else begin
                            n_fmt_left = fmt_dec;
                            if (fmt_dec == 8'd0)
                                n_phase = PH_STRINGS;
                        end
                    end
                    default: begin
                        if (r_inside) begin
                            if (i_data_byte == 8'd0)
                                n_inside = 1'b0;
                        end else if (r_strings != 8'd0 && i_data_byte == 8'd0) begin
                            set_ends = 1'b1;
                        end else begin
                            if (r_strings != 8'hFF)
                                n_strings = r_strings + 8'd1;
                            n_inside = (i_data_byte != 8'd0);
                        end
                        if (set_ends || i_last_byte) begin
                            emit_struct = 1'b1;
                            if (r_done != 16'hFFFF)
                                n_done = r_done + 16'd1;
                        end
                        if (set_ends) begin
                            n_phase    = PH_HEADER;
                            n_hdr_seen = 2'd0;
                            n_strings  = 8'd0;
                            n_inside   = 1'b0;
                            n_start    = pos_next;
                        end
                    end
                endcase
            end

            if (err != ST_OK) begin
                emit_end   = 1'b1;
                end_offset = sat_offset(n_start);
                n_failed   = 1'b1;
            end else begin
                n_pos = pos_next;
                if (i_last_byte) begin
                    emit_end   = 1'b1;
                    end_offset = sat_offset(pos_next);
                end
            end
        end
    end

    always_comb begin
        new_slot.has_struct = emit_struct;
        new_slot.has_end    = emit_end;
        new_slot.s_type     = r_type;
        new_slot.s_handle   = r_handle;
        new_slot.s_length   = r_length;
        // a set that ends reports the count it had before the closing zero
        new_slot.s_count    = set_ends ? r_strings : n_strings;
        new_slot.s_offset   = sat_offset(r_start);
        new_slot.e_offset   = end_offset;
        new_slot.e_total    = n_done;
        new_slot.e_status   = err;
    end

    // parser registers; the final byte of a table always starts a fresh table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_accept && i_last_byte)) begin
            r_phase    <= PH_HEADER;
            r_hdr_seen <= 2'd0;
            r_type     <= 8'd0;
            r_length   <= 8'd0;
            r_handle   <= 16'd0;
            r_fmt_left <= 8'd0;
            r_strings  <= 8'd0;
            r_inside   <= 1'b0;
            r_pos      <= '0;
            r_start    <= '0;
            r_done     <= 16'd0;
            r_failed   <= 1'b0;
        end else if (in_accept) begin
            r_phase    <= n_phase;
            r_hdr_seen <= n_hdr_seen;
            r_type     <= n_type;
            r_length   <= n_length;
            r_handle   <= n_handle;
            r_fmt_left <= n_fmt_left;
            r_strings  <= n_strings;
            r_inside   <= n_inside;
            r_pos      <= n_pos;
            r_start    <= n_start;
            r_done     <= n_done;
            r_failed   <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_TABLE_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_bytes <= i_cfg_wr_data;
        end
    end

    // result queue
    assign push       = in_accept && (emit_struct || emit_end);
    assign head_slot  = r_slot[r_head];
    assign out_accept = o_out_valid && !i_out_stall;
    // a two-record entry leaves only after its second transaction
    assign pop        = out_accept && !(head_slot.has_struct && head_slot.has_end && !r_half);

    always_ff @(posedge i_clk) begin
        if (push)
            r_slot[r_tail] <= new_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
            r_half  <= 1'b0;
        end else begin
            if (push)
                r_tail <= ~r_tail;
            if (pop)
                r_head <= ~r_head;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
            if (pop)
                r_half <= 1'b0;
            else if (out_accept)
                r_half <= 1'b1;
        end
    end

    // output selection from the head entry
    assign o_out_valid = (r_count != 2'd0);

    always_comb begin
        if (head_slot.has_struct && !r_half) begin
            o_record_kind      = KIND_STRUCT;
            o_struct_type      = head_slot.s_type;
            o_struct_handle    = head_slot.s_handle;
            o_formatted_length = head_slot.s_length;
            o_string_count     = head_slot.s_count;
            o_struct_offset    = head_slot.s_offset;
            o_struct_total     = 16'd0;
            o_status           = ST_OK;
            o_last_result      = !head_slot.has_end;
        end else begin
            o_record_kind      = KIND_TABLE_END;
            o_struct_type      = 8'd0;
            o_struct_handle    = 16'd0;
            o_formatted_length = 8'd0;
            o_string_count     = 8'd0;
            o_struct_offset    = head_slot.e_offset;
            o_struct_total     = head_slot.e_total;
            o_status           = head_slot.e_status;
            o_last_result      = 1'b1;
        end
    end

endmodule

// ===== sim/smbios_structure_table_parser_tb.sv =====
`timescale 1ns / 1ps

module smbios_structure_table_parser_tb;

    import sstp_pkg::*;

    // run sizing
    localparam int ITEM_TARGET   = 1550;     // offered table bytes before the stimulus stops
    localparam int SETTLE_CYCLES = 8;        // quiet cycles before a limit write and at the end
    localparam int LIMIT_CYCLES  = 400000;   // watchdog
    localparam int REPORT_MAX    = 10;
    localparam int N_DIRECTED    = 28;
    localparam int N_LIMITS      = 8;

    // header byte order inside a structure
    localparam logic [1:0] HDR_TYPE  = 2'd0;
    localparam logic [1:0] HDR_LEN   = 2'd1;
    localparam logic [1:0] HDR_HND_L = 2'd2;
    localparam logic [1:0] HDR_HND_H = 2'd3;

    // byte positions saturate at the top of the offset range
    localparam logic [23:0] POS_TOP = 24'hFF_FFFF;

    // one output record, field for field as the ports show it
    typedef struct packed {
        logic        kind;
        logic [7:0]  stype;
        logic [15:0] handle;
        logic [7:0]  flen;
        logic [7:0]  nstr;
        logic [23:0] offset;
        logic [15:0] total;
        t_status     status;
        logic        last;
    } t_record;

    // one table byte; pin marks a row whose table end record is typed in below
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        pin;
        t_status     pin_status;
        logic [15:0] pin_total;
        logic [23:0] pin_offset;
    } t_row;

    // receiver stall patterns
    typedef enum logic [2:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY,
        RX_TOGGLE
    } t_rx_mode;

    // dut connections; the inputs are known from time zero
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [23:0]       i_cfg_wr_data = 24'd0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_data_byte   = 8'd0;
    logic              i_last_byte   = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic              o_record_kind;
    logic [7:0]        o_struct_type;
    logic [15:0]       o_struct_handle;
    logic [7:0]        o_formatted_length;
    logic [7:0]        o_string_count;
    logic [23:0]       o_struct_offset;
    logic [15:0]       o_struct_total;
    t_status           o_status;
    logic              o_last_result;

    // parser state as the testbench tracks it
    t_phase            p_phase;
    logic [1:0]        p_hdr_idx;
    logic [7:0]        p_type;
    logic [7:0]        p_len;
    logic [15:0]       p_handle;
    logic [7:0]        p_fmt_left;
    logic [7:0]        p_strings;
    logic              p_in_string;
    logic [23:0]       p_pos;
    logic [23:0]       p_start;
    logic [15:0]       p_done;
    logic              p_failed;
    logic [23:0]       p_limit;

    // records still owed by the dut, oldest first
    t_record           expected_records [$];

    // bytes of the table being sent
    logic [7:0]        tbl_bytes [$];
    int                tbl_len;

    // sender bookkeeping
    int                burst_left    = 0;
    int                sent_bytes    = 0;
    int                parsed_bytes  = 0;
    int                tables_sent   = 0;
    int                limits_used   = 0;
    int                hold_req      = 0;

    // receiver bookkeeping
    t_rx_mode          rx_mode       = RX_FREE;
    int                rx_mode_left  = 0;
    int                hold_ack      = 0;
    int                hold_left     = 0;

    // checker bookkeeping
    int                failures      = 0;
    int                struct_seen   = 0;
    int                end_seen      = 0;
    int                end_by_status [5] = '{0, 0, 0, 0, 0};
    int                cycles        = 0;

    // directed rows: a well-formed two-structure table, extreme field values, then a cut
    // header, two short lengths and data ending early; only table end records are typed in
    t_row directed_rows [N_DIRECTED] = '{
        // structure at 0: type ff, length 5, handle ffff, one formatted byte, one string
        '{8'hFF, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h05, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'hFF, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'hFF, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'hAA, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h41, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        // structure at 8: all-zero header fields, leading zero as empty string,
        // set ends on the last byte -> structure record plus clean table end
        '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h04, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b1, 1'b1, ST_OK, 16'd2, 24'd14},
        // table of one byte: header cut short
        '{8'h7F, 1'b1, 1'b1, ST_TRUNC_HDR, 16'd0, 24'd0},
        // length 3, then a byte that is dropped after the error
        '{8'h01, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h03, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h34, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h12, 1'b0, 1'b1, ST_SHORT_LEN, 16'd0, 24'd0},
        '{8'hFF, 1'b1, 1'b0, ST_OK, 16'd0, 24'd0},
        // length 2 with the header closing on the last byte
        '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h02, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b1, 1'b1, ST_SHORT_LEN, 16'd0, 24'd0},
        // good length but the table stops right after the header
        '{8'h11, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h08, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 24'd0},
        '{8'h00, 1'b1, 1'b1, ST_DATA_ENDS, 16'd0, 24'd0}
    };

    // limit settings walked by the random part; the slot holding 0 at index 6
    // is replaced by a random small limit
    logic [23:0] limit_values [N_LIMITS] = '{
        24'd0, 24'd9, 24'd1, 24'd40, 24'd4, MAX_TABLE_RESET, 24'd0, 24'd200
    };

    smbios_structure_table_parser DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_record_kind      (o_record_kind),
        .o_struct_type      (o_struct_type),
        .o_struct_handle    (o_struct_handle),
        .o_formatted_length (o_formatted_length),
        .o_string_count     (o_string_count),
        .o_struct_offset    (o_struct_offset),
        .o_struct_total     (o_struct_total),
        .o_status           (o_status),
        .o_last_result      (o_last_result)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------

    // everything but the limit register goes back to its start value
    task automatic clear_table();
        p_phase     = PH_HEADER;
        p_hdr_idx   = HDR_TYPE;
        p_type      = 8'd0;
        p_len       = 8'd0;
        p_handle    = 16'd0;
        p_fmt_left  = 8'd0;
        p_strings   = 8'd0;
        p_in_string = 1'b0;
        p_pos       = 24'd0;
        p_start     = 24'd0;
        p_done      = 16'd0;
        p_failed    = 1'b0;
    endtask

    function automatic logic [23:0] pos_next(input logic [23:0] pos);
        return (pos == POS_TOP) ? pos : pos + 24'd1;
    endfunction

    function automatic t_record end_record(input logic [23:0] off, input logic [15:0] tot,
                                           input t_status st);
        t_record r;
        r        = '0;
        r.kind   = KIND_TABLE_END;
        r.offset = off;
        r.total  = tot;
        r.status = st;
        return r;
    endfunction

    // works out the records one accepted byte causes and advances the state
    task automatic predict_records(input logic [7:0] b, input logic l,
                                   output t_record r0, output t_record r1,
                                   output int n, output logic skipped);
        t_record     recs [2];
        t_status     err;
        logic [23:0] at;
        logic [1:0]  k;
        logic        set_ends;
        recs[0]  = '0;
        recs[1]  = '0;
        n        = 0;
        err      = ST_OK;
        at       = p_pos;
        k        = p_hdr_idx;
        set_ends = 1'b0;
        skipped  = p_failed;
        if (p_failed) begin
            // bytes after an error are dropped up to the end of the table
            if (l) clear_table();
        end else begin
            if (at >= p_limit) begin
                // the length check comes first and masks any other error
                err = ST_TOO_LONG;
            end else if (p_phase == PH_HEADER) begin
                case (k)
                    HDR_TYPE: begin
                        p_type  = b;
                        p_start = at;
                    end
                    HDR_LEN:   p_len = b;
                    HDR_HND_L: p_handle = {8'h00, b};
                    default:   p_handle[15:8] = b;
                endcase
                if (k != HDR_HND_H) begin
                    p_hdr_idx = k + 2'd1;
                    if (l) err = ST_TRUNC_HDR;
                end else begin
                    p_hdr_idx = HDR_TYPE;
                    if (p_len < HEADER_LEN) begin
                        err = ST_SHORT_LEN;
                    end else if (l) begin
                        err = ST_DATA_ENDS;
                    end else begin
                        p_fmt_left  = p_len - HEADER_LEN;
                        p_strings   = 8'd0;
                        p_in_string = 1'b0;
                        p_phase     = (p_fmt_left != 8'd0) ? PH_FORMATTED : PH_STRINGS;
                    end
                end
            end else if (p_phase == PH_FORMATTED) begin
                if (l) begin
                    err = ST_DATA_ENDS;
                end else begin
                    p_fmt_left = p_fmt_left - 8'd1;
                    if (p_fmt_left == 8'd0) p_phase = PH_STRINGS;
                end
            end else begin
                if (p_in_string) begin
                    if (b == 8'd0) p_in_string = 1'b0;
                end else if (p_strings != 8'd0 && b == 8'd0) begin
                    set_ends = 1'b1;
                end else begin
                    // a zero here before any string is an empty string
                    if (p_strings != 8'hFF) p_strings = p_strings + 8'd1;
                    p_in_string = (b != 8'd0);
                end
                if (set_ends || l) begin
                    if (p_done != 16'hFFFF) p_done = p_done + 16'd1;
                    recs[n].kind   = KIND_STRUCT;
                    recs[n].stype  = p_type;
                    recs[n].handle = p_handle;
                    recs[n].flen   = p_len;
                    recs[n].nstr   = p_strings;
                    recs[n].offset = p_start;
                    n++;
                end
                if (set_ends) begin
                    p_phase     = PH_HEADER;
                    p_hdr_idx   = HDR_TYPE;
                    p_strings   = 8'd0;
                    p_in_string = 1'b0;
                    p_start     = pos_next(at);
                end
            end
            if (err != ST_OK) begin
                recs[n] = end_record(p_start, p_done, err);
                n++;
                p_failed = 1'b1;
            end else begin
                p_pos = pos_next(at);
                if (l) begin
                    recs[n] = end_record(p_pos, p_done, ST_OK);
                    n++;
                end
            end
            if (n > 0) recs[n - 1].last = 1'b1;
            if (l) clear_table();
        end
        r0 = recs[0];
        r1 = recs[1];
    endtask

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // offers one byte in bursts with random gaps, then books its records
    task automatic send_byte(input t_row row);
        t_record r0;
        t_record r1;
        t_record pinned;
        int      n;
        int      gap;
        logic    skipped;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_data_byte <= row.data;
        i_last_byte <= row.last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // transaction taken at this edge
        predict_records(row.data, row.last, r0, r1, n, skipped);
        if (row.pin) begin
            // typed-in table end record takes the place of the predicted one
            pinned      = end_record(row.pin_offset, row.pin_total, row.pin_status);
            pinned.last = 1'b1;
            if (n == 2) begin
                r1 = pinned;
            end else begin
                r0 = pinned;
                n  = 1;
            end
        end
        if (n > 0) expected_records.push_back(r0);
        if (n > 1) expected_records.push_back(r1);
        sent_bytes++;
        if (!skipped) parsed_bytes++;
    endtask

    // waits until the block is quiet, then writes max_table_bytes
    task automatic write_limit(input logic [23:0] value);
        i_in_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        p_limit = value;
        i_cfg_wr_en <= 1'b0;
        limits_used++;
    endtask

    // fills tbl_bytes with one table: mostly well-formed structures with
    // random content, some cut short, some pure noise
    task automatic build_table(input logic many_strings);
        int n_struct;
        int n_str;
        int slen;
        int flen;
        int pick;
        int s;
        int k;
        tbl_bytes.delete();
        if (!many_strings && $urandom_range(0, 99) < 12) begin
            n_struct = $urandom_range(1, 24);
            for (k = 0; k < n_struct; k++) tbl_bytes.push_back(8'($urandom));
        end else begin
            n_struct = many_strings ? 1 : $urandom_range(1, 4);
            for (s = 0; s < n_struct; s++) begin
                // mostly short formatted areas, a few under 4, rarely huge
                pick = $urandom_range(0, 199);
                if (pick < 8) flen = $urandom_range(0, 3);
                else if (pick == 8) flen = $urandom_range(200, 255);
                else flen = $urandom_range(4, 14);
                tbl_bytes.push_back(8'($urandom));
                tbl_bytes.push_back(8'(flen));
                tbl_bytes.push_back(8'($urandom));
                tbl_bytes.push_back(8'($urandom));
                for (k = 4; k < flen; k++) tbl_bytes.push_back(8'($urandom));
                // enough one-char strings once to saturate the string count
                n_str = many_strings ? $urandom_range(256, 262) : $urandom_range(0, 4);
                if (n_str == 0) tbl_bytes.push_back(8'h00);
                for (k = 0; k < n_str; k++) begin
                    slen = many_strings ? 1 : $urandom_range(1, 6);
                    repeat (slen) tbl_bytes.push_back(8'($urandom_range(1, 255)));
                    tbl_bytes.push_back(8'h00);
                end
                tbl_bytes.push_back(8'h00);
            end
            // some tables carry junk after the last set
            if (!many_strings && $urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) tbl_bytes.push_back(8'($urandom));
            end
        end
        tbl_len = tbl_bytes.size();
        // cut short anywhere: header, formatted area or string set
        if (!many_strings && $urandom_range(0, 99) < 35) tbl_len = $urandom_range(1, tbl_len);
    endtask

    initial begin : stimulus
        t_row        row;
        int          i;
        int          tbl_idx;
        logic [23:0] value;
        clear_table();
        p_limit = MAX_TABLE_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows run against the reset value of the limit
        for (i = 0; i < N_DIRECTED; i++) send_byte(directed_rows[i]);
        tables_sent += 5;

        // random tables, the limit moving every 8 tables
        tbl_idx = 0;
        while (sent_bytes < ITEM_TARGET) begin
            if (tbl_idx > 0 && tbl_idx % 8 == 0) begin
                value = limit_values[limits_used % N_LIMITS];
                if (limits_used % N_LIMITS == 6) value = 24'($urandom_range(5, 80));
                write_limit(value);
            end
            // ask the receiver for a long hold while this table streams in
            if (tbl_idx % 40 == 5) hold_req <= hold_req + 1;
            build_table(tbl_idx == 3);
            for (i = 0; i < tbl_len; i++) begin
                row      = '0;
                row.data = tbl_bytes[i];
                row.last = (i == tbl_len - 1);
                send_byte(row);
            end
            tbl_idx++;
            tables_sent++;
        end

        // drain and let any stray record show up
        i_in_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d tables, %0d bytes offered, %0d parsed, %0d limit settings",
                 tables_sent, sent_bytes, parsed_bytes, limits_used);
        $display({"checked %0d structure and %0d table end records ",
                  "(ok %0d, trunc %0d, short %0d, ends %0d, long %0d)"},
                 struct_seen, end_seen, end_by_status[0], end_by_status[1],
                 end_by_status[2], end_by_status[3], end_by_status[4]);
        if (failures == 0 && expected_records.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern changes at random intervals, with long
    // holds on request so the result queue fills and the input backs up
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= $urandom_range(60, 99);
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_mode'($urandom_range(0, 4));
                rx_mode_left <= $urandom_range(32, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:   i_out_stall <= 1'b0;
                RX_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HALF:   i_out_stall <= ($urandom_range(0, 1) == 0);
                RX_HEAVY:  i_out_stall <= ($urandom_range(0, 4) != 0);
                default:   i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // checker: every record taken off the output against the oldest
    // expectation
    // ------------------------------------------------------------------
    function automatic string record_text(input t_record r);
        return $sformatf({"kind=%0d type=%02h handle=%04h len=%0d strings=%0d ",
                          "offset=%0d total=%0d status=%0d last=%0d"},
                         r.kind, r.stype, r.handle, r.flen, r.nstr,
                         r.offset, r.total, r.status, r.last);
    endfunction

    always @(posedge i_clk) begin : check_records
        t_record seen_rec;
        t_record want_rec;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_rec.kind   = o_record_kind;
            seen_rec.stype  = o_struct_type;
            seen_rec.handle = o_struct_handle;
            seen_rec.flen   = o_formatted_length;
            seen_rec.nstr   = o_string_count;
            seen_rec.offset = o_struct_offset;
            seen_rec.total  = o_struct_total;
            seen_rec.status = o_status;
            seen_rec.last   = o_last_result;
            if (expected_records.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: record with none expected: %s", $time, record_text(seen_rec));
            end else begin
                want_rec = expected_records.pop_front();
                if (want_rec.kind == KIND_STRUCT) begin
                    struct_seen++;
                end else begin
                    end_seen++;
                    end_by_status[int'(want_rec.status)]++;
                end
                if (seen_rec !== want_rec) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $display("%0t: record mismatch", $time);
                        $display("  expected %s", record_text(want_rec));
                        $display("  actual   %s", record_text(seen_rec));
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d records outstanding",
                     cycles, expected_records.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
